@@ design/tlv_pkg.sv @@
// tlv_pkg: shared constants and types of the tag finder
// no dependencies; used by the result channel interface, the top level and the checker
`default_nettype none

package tlv_pkg;

  // longest buffer that is parsed; bytes beyond it flag the buffer as too long
  localparam int unsigned BUFFER_BYTES = 4096;
  // byte counter holds 0 .. BUFFER_BYTES
  localparam int unsigned POS_W        = $clog2(BUFFER_BYTES + 1);

  // length byte codes
  localparam logic [7:0] LEN_LONG_MARK = 8'h80;
  localparam logic [7:0] LEN_ONE_BYTE  = 8'h81;
  localparam logic [7:0] LEN_TWO_BYTE  = 8'h82;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_FOUND     = 2'd0;
  localparam status_t STATUS_NOT_FOUND = 2'd1;
  localparam status_t STATUS_TOO_LONG  = 2'd2;

endpackage

`default_nettype wire

@@ design/tlv_in_if.sv @@
// tlv_in_if: byte stream channel into the tag finder (valid/ready plus payload)
// depends on nothing
`default_nettype none

interface tlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [7:0] target_tag;

  modport source (output valid, output data_byte, output last_byte, output target_tag,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input target_tag,
                  output ready);
endinterface

`default_nettype wire

@@ design/tlv_out_if.sv @@
// tlv_out_if: search result channel out of the tag finder (valid/ready plus payload)
// depends on tlv_pkg for the status type
`default_nettype none

interface tlv_out_if;
  logic              valid;
  logic              ready;
  tlv_pkg::status_t  search_status;
  logic [15:0]       value_offset;
  logic [15:0]       value_length;

  modport source (output valid, output search_status, output value_offset,
                  output value_length, input ready);
  modport sink   (input valid, input search_status, input value_offset,
                  input value_length, output ready);
endinterface

`default_nettype wire

@@ design/tlv_tag_finder.sv @@
// tlv_tag_finder: streaming search for one tag in a single-byte-tag BER-TLV buffer
// depends on tlv_pkg, tlv_in_if and tlv_out_if
//
//   channel   | dir | payload                                    | one transaction
//   ----------+-----+--------------------------------------------+-------------------------
//   in_chan   | in  | data_byte[7:0], last_byte, target_tag[7:0] | one buffer byte
//   out_chan  | out | search_status[1:0], value_offset[15:0],    | one result per buffer,
//             |     | value_length[15:0]                         | after its last byte
//
// one byte is taken per cycle while in_chan.ready is high; the parse state updates in the cycle the byte is accepted.
// the result is registered and shows in the cycle after the last byte is accepted.
// in_chan.ready drops only while a result is held and out_chan.ready is low, so the
// next buffer streams in while the previous result is still being taken.
// synchronous active-low reset returns the parser to expect a tag byte, with no result.
`default_nettype none

module tlv_tag_finder (
  input  wire        clk,
  input  wire        rst_n,
  tlv_in_if.sink     in_chan,
  tlv_out_if.source  out_chan
);
  import tlv_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG, PH_LEN, PH_LEN1, PH_LEN2HI, PH_LEN2LO, PH_VALUE, PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    SO_SEARCH, SO_PENDING, SO_FOUND, SO_STOPPED
  } over_t;

  phase_t           phase_r, phase_nxt;
  over_t            over_r, over_nxt;
  logic [POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [7:0]       sought_tag_r, sought_tag_nxt;
  logic [7:0]       item_tag_r, item_tag_nxt;
  logic [15:0]      remaining_r, remaining_nxt;
  logic [15:0]      held_offset_r, held_offset_nxt;
  logic [15:0]      held_length_r, held_length_nxt;
  logic             too_long_r, too_long_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [15:0]      out_offset_r, out_offset_nxt;
  logic [15:0]      out_length_r, out_length_nxt;

  logic             in_acc;
  logic             pos_full;
  logic [16:0]      value_start;
  logic [15:0]      value_start_sat;
  logic [15:0]      remaining_dec;
  logic             begin_now;
  logic [15:0]      begin_len;

  // accept whenever the result register is free or being emptied
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign pos_full        = byte_pos_r >= POS_W'(BUFFER_BYTES);
  assign value_start     = 17'(byte_pos_r) + 17'd1;
  assign value_start_sat = value_start[16] ? 16'hFFFF : value_start[15:0];
  assign remaining_dec   = remaining_r - 16'd1;

  // parse step for one accepted byte
  always_comb begin
    phase_nxt       = phase_r;
    over_nxt        = over_r;
    byte_pos_nxt    = byte_pos_r;
    sought_tag_nxt  = sought_tag_r;
    item_tag_nxt    = item_tag_r;
    remaining_nxt   = remaining_r;
    held_offset_nxt = held_offset_r;
    held_length_nxt = held_length_r;
    too_long_nxt    = too_long_r;
    begin_now       = 1'b0;
    begin_len       = {8'h00, in_chan.data_byte};

    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_length_nxt = out_length_r;

    if (in_acc) begin
      if (byte_pos_r == '0) begin
        sought_tag_nxt = in_chan.target_tag;
      end

      if (pos_full) begin
        too_long_nxt = 1'b1;
      end else begin
        byte_pos_nxt = byte_pos_r + POS_W'(1);
        unique case (phase_r)
          PH_TAG: begin
            item_tag_nxt = in_chan.data_byte;
            phase_nxt    = PH_LEN;
          end
          PH_LEN: begin
            priority if (in_chan.data_byte < LEN_LONG_MARK) begin
              begin_now = 1'b1;
            end else if (in_chan.data_byte == LEN_ONE_BYTE) begin
              phase_nxt = PH_LEN1;
            end else if (in_chan.data_byte == LEN_TWO_BYTE) begin
              phase_nxt = PH_LEN2HI;
            end else begin
              // unsupported length form ends the search
              over_nxt  = SO_STOPPED;
              phase_nxt = PH_IDLE;
            end
          end
          PH_LEN1: begin
            begin_now = 1'b1;
          end
          PH_LEN2HI: begin
            remaining_nxt = {8'h00, in_chan.data_byte};
            phase_nxt     = PH_LEN2LO;
          end
          PH_LEN2LO: begin
            begin_now = 1'b1;
            begin_len = {remaining_r[7:0], in_chan.data_byte};
          end
          PH_VALUE: begin
            remaining_nxt = remaining_dec;
            if (remaining_dec == 16'd0) begin
              if (over_r == SO_PENDING) begin
                over_nxt  = SO_FOUND;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_TAG;
              end
            end
          end
          PH_IDLE: begin
          end
          default: begin
          end
        endcase

        // header complete: start the value, and hold it if the tag matches while still searching
        if (begin_now) begin
          if (over_r == SO_SEARCH && item_tag_r == sought_tag_r) begin
            held_offset_nxt = value_start_sat;
            held_length_nxt = begin_len;
            if (begin_len == 16'd0) begin
              over_nxt  = SO_FOUND;
              phase_nxt = PH_IDLE;
            end else begin
              over_nxt      = SO_PENDING;
              remaining_nxt = begin_len;
              phase_nxt     = PH_VALUE;
            end
          end else if (begin_len == 16'd0) begin
            phase_nxt = PH_TAG;
          end else begin
            remaining_nxt = begin_len;
            phase_nxt     = PH_VALUE;
          end
        end
      end

      // final byte: load the result and rearm for the next buffer
      if (in_chan.last_byte) begin
        out_valid_nxt = 1'b1;
        if (too_long_nxt) begin
          out_status_nxt = STATUS_TOO_LONG;
          out_offset_nxt = 16'd0;
          out_length_nxt = 16'd0;
        end else if (over_nxt == SO_FOUND) begin
          out_status_nxt = STATUS_FOUND;
          out_offset_nxt = held_offset_nxt;
          out_length_nxt = held_length_nxt;
        end else begin
          out_status_nxt = STATUS_NOT_FOUND;
          out_offset_nxt = 16'd0;
          out_length_nxt = 16'd0;
        end
        phase_nxt       = PH_TAG;
        over_nxt        = SO_SEARCH;
        byte_pos_nxt    = '0;
        sought_tag_nxt  = 8'h00;
        item_tag_nxt    = 8'h00;
        remaining_nxt   = 16'd0;
        held_offset_nxt = 16'd0;
        held_length_nxt = 16'd0;
        too_long_nxt    = 1'b0;
      end
    end
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_TAG;
      over_r        <= SO_SEARCH;
      byte_pos_r    <= '0;
      sought_tag_r  <= 8'h00;
      item_tag_r    <= 8'h00;
      remaining_r   <= 16'd0;
      held_offset_r <= 16'd0;
      held_length_r <= 16'd0;
      too_long_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      over_r        <= over_nxt;
      byte_pos_r    <= byte_pos_nxt;
      sought_tag_r  <= sought_tag_nxt;
      item_tag_r    <= item_tag_nxt;
      remaining_r   <= remaining_nxt;
      held_offset_r <= held_offset_nxt;
      held_length_r <= held_length_nxt;
      too_long_r    <= too_long_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_length_r <= out_length_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.search_status = out_status_r;
  assign out_chan.value_offset  = out_offset_r;
  assign out_chan.value_length  = out_length_r;

endmodule

`default_nettype wire

@@ design/tlv_chk.sv @@
// tlv_chk: port-level checks of the tag finder, attached by bind
// depends on tlv_pkg and on the tlv_tag_finder ports
`default_nettype none

module tlv_chk (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input wire               in_last,
  input wire               out_valid,
  input wire               out_ready,
  input wire [1:0]         out_status,
  input wire [15:0]        out_offset,
  input wire [15:0]        out_length
);
  import tlv_pkg::*;

  // a held result stays until its transaction completes
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a new result only follows an accepted last byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
    else $error("result without a final byte");

  // a found value starts past a header of at least two bytes
  a_found_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FOUND |-> out_offset >= 16'd2)
    else $error("found offset inside the first header");

  // only found results carry offset and length
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_FOUND |-> out_offset == 16'd0 && out_length == 16'd0)
    else $error("offset or length set on a miss");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STATUS_FOUND || out_status == STATUS_NOT_FOUND ||
                  out_status == STATUS_TOO_LONG)
    else $error("undefined status code");

endmodule

bind tlv_tag_finder tlv_chk u_tlv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_last    (in_chan.last_byte),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.search_status),
  .out_offset (out_chan.value_offset),
  .out_length (out_chan.value_length)
);

`default_nettype wire

@@ tb/tlv_tag_finder_tb.sv @@
// tlv_tag_finder_tb: self-checking testbench of the streaming tag finder
// depends on tlv_pkg, tlv_in_if, tlv_out_if and tlv_tag_finder; a short byte table runs
// first, then random buffers that are checked against a cycle-free prediction of the search
`default_nettype none

module tlv_tag_finder_tb;
  import tlv_pkg::*;

  localparam int RANDOM_BYTES = 900;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    status_t     search_status;
    logic [15:0] value_offset;
    logic [15:0] value_length;
  } search_result_t;

  // one byte of the directed table; the expected result is typed in only where marked
  typedef struct packed {
    logic [7:0]     data;
    logic           last;
    logic [7:0]     tag;
    logic           typed;
    search_result_t want;
  } stim_row_t;

  // where the walk stands inside the current item
  typedef enum logic [2:0] {
    SCAN_TAG, SCAN_LEN, SCAN_LEN_ONE, SCAN_LEN_HI, SCAN_LEN_LO, SCAN_VALUE, SCAN_DONE
  } scan_phase_t;

  // how far the search for the sought tag has come
  typedef enum logic [1:0] {HUNT, MATCH_OPEN, MATCH_FOUND, HUNT_STOPPED} hunt_t;

  localparam stim_row_t DIRECTED [25] = '{
    // single byte: header incomplete
    '{8'h5A, 1'b1, 8'h5A, 1'b1, '{STATUS_NOT_FOUND, 16'd0, 16'd0}},
    // empty match right after its header
    '{8'h11, 1'b0, 8'h11, 1'b0, '0},
    '{8'h00, 1'b1, 8'hFF, 1'b1, '{STATUS_FOUND, 16'd2, 16'd0}},
    // bad length byte stops the search, later match ignored
    '{8'h11, 1'b0, 8'h11, 1'b0, '0},
    '{8'h80, 1'b0, 8'h00, 1'b0, '0},
    '{8'h11, 1'b1, 8'h11, 1'b1, '{STATUS_NOT_FOUND, 16'd0, 16'd0}},
    // one-byte long length
    '{8'h22, 1'b0, 8'h22, 1'b0, '0},
    '{8'h81, 1'b0, 8'hFF, 1'b0, '0},
    '{8'h01, 1'b0, 8'h00, 1'b0, '0},
    '{8'hFF, 1'b1, 8'hFF, 1'b1, '{STATUS_FOUND, 16'd3, 16'd1}},
    // two-byte long length
    '{8'h33, 1'b0, 8'h33, 1'b0, '0},
    '{8'h82, 1'b0, 8'h00, 1'b0, '0},
    '{8'h00, 1'b0, 8'hFF, 1'b0, '0},
    '{8'h02, 1'b0, 8'h00, 1'b0, '0},
    '{8'hAA, 1'b0, 8'hFF, 1'b0, '0},
    '{8'h55, 1'b1, 8'h00, 1'b1, '{STATUS_FOUND, 16'd4, 16'd2}},
    // other item skipped, then match with tag zero
    '{8'hFF, 1'b0, 8'h00, 1'b0, '0},
    '{8'h01, 1'b0, 8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, 8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, 8'hFF, 1'b0, '0},
    '{8'h01, 1'b0, 8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, 8'hFF, 1'b0, '0},
    // matched value cut short by the buffer end
    '{8'h44, 1'b0, 8'h44, 1'b0, '0},
    '{8'h7F, 1'b0, 8'h00, 1'b0, '0},
    '{8'h01, 1'b1, 8'hFF, 1'b1, '{STATUS_NOT_FOUND, 16'd0, 16'd0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  tlv_in_if  in_chan ();
  tlv_out_if out_chan ();

  tlv_tag_finder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 20-unit clock period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // search state of the prediction
  scan_phase_t scan_phase;
  hunt_t       hunt_state;
  int unsigned scan_pos;
  int unsigned skip_left;
  logic [7:0]  want_tag;
  logic [7:0]  cur_tag;
  logic [15:0] hit_offset;
  logic [15:0] hit_length;
  logic        overflowed;

  search_result_t pending_results [$];
  logic [7:0]     frame_bytes [$];

  // typed expectation travelling with the byte on offer
  logic           offer_typed;
  search_result_t offer_want;

  logic src_burst;
  logic hold_done;
  int   errors;
  int   results_seen;
  int   bytes_sent;
  int   found_count;
  int   missing_count;
  int   too_long_count;
  int   cycle_count;

  function automatic void clear_search();
    scan_phase = SCAN_TAG;
    hunt_state = HUNT;
    scan_pos   = 0;
    skip_left  = 0;
    want_tag   = 8'h00;
    cur_tag    = 8'h00;
    hit_offset = 16'h0000;
    hit_length = 16'h0000;
    overflowed = 1'b0;
  endfunction

  // header complete: remember a match or skip the value
  function automatic void open_value(int unsigned len, int unsigned pos);
    int unsigned off;
    off = pos + 1;
    if (hunt_state == HUNT && cur_tag == want_tag) begin
      hit_offset = (off > 65535) ? 16'hFFFF : off[15:0];
      hit_length = len[15:0];
      if (len == 0) begin
        hunt_state = MATCH_FOUND;
        scan_phase = SCAN_DONE;
      end else begin
        hunt_state = MATCH_OPEN;
        skip_left  = len;
        scan_phase = SCAN_VALUE;
      end
    end else if (len == 0) begin
      scan_phase = SCAN_TAG;
    end else begin
      skip_left  = len;
      scan_phase = SCAN_VALUE;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, int unsigned pos);
    case (scan_phase)
      SCAN_TAG: begin
        cur_tag    = b;
        scan_phase = SCAN_LEN;
      end
      SCAN_LEN: begin
        if (b < LEN_LONG_MARK) begin
          open_value(32'(b), pos);
        end else if (b == LEN_ONE_BYTE) begin
          scan_phase = SCAN_LEN_ONE;
        end else if (b == LEN_TWO_BYTE) begin
          scan_phase = SCAN_LEN_HI;
        end else begin
          hunt_state = HUNT_STOPPED;
          scan_phase = SCAN_DONE;
        end
      end
      SCAN_LEN_ONE: open_value(32'(b), pos);
      SCAN_LEN_HI: begin
        skip_left  = 32'(b);
        scan_phase = SCAN_LEN_LO;
      end
      SCAN_LEN_LO: open_value(32'({skip_left[7:0], b}), pos);
      SCAN_VALUE: begin
        skip_left = (skip_left - 1) & 32'hFFFF;
        if (skip_left == 0) begin
          if (hunt_state == MATCH_OPEN) begin
            hunt_state = MATCH_FOUND;
            scan_phase = SCAN_DONE;
          end else begin
            scan_phase = SCAN_TAG;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // advance the search by one byte; returns 1 when the buffer ends with a result
  function automatic logic predict_byte(logic [7:0] b, logic last, logic [7:0] tag,
                                        output search_result_t res);
    res = '0;
    if (scan_pos == 0 && !overflowed) want_tag = tag;
    if (scan_pos >= BUFFER_BYTES) begin
      overflowed = 1'b1;
    end else begin
      parse_byte(b, scan_pos);
      scan_pos++;
    end
    if (!last) return 1'b0;
    if (overflowed) res.search_status = STATUS_TOO_LONG;
    else if (hunt_state == MATCH_FOUND) res = '{STATUS_FOUND, hit_offset, hit_length};
    else res.search_status = STATUS_NOT_FOUND;
    clear_search();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("mismatch on result %0d, %s: got %0d, expected %0d", results_seen, what, got,
               want);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one byte and wait for its transaction
  task automatic send_byte(input logic [7:0] data, input logic last, input logic [7:0] tag,
                           input logic typed, input search_result_t want);
    int gap;
    gap = src_burst ? 0 : idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid     = 1'b0;
      in_chan.data_byte = 8'($urandom);
      in_chan.last_byte = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_chan.valid     = 1'b1;
    in_chan.data_byte = data;
    in_chan.last_byte = last;
    in_chan.target_tag = tag;
    offer_typed       = typed;
    offer_want        = want;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] want);
    int i;
    for (i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, (i == 0) ? want : 8'($urandom),
                1'b0, '0);
  endtask

  // one tlv item with a random length form and random value
  task automatic push_item(input logic [7:0] tag);
    int form;
    int len;
    logic [7:0] hi;
    frame_bytes.push_back(tag);
    form = $urandom_range(0, 9);
    if (form < 7) begin
      len = (form == 6) ? $urandom_range(0, 127) : $urandom_range(0, 12);
      frame_bytes.push_back(8'(len));
    end else if (form < 9) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      frame_bytes.push_back(LEN_ONE_BYTE);
      frame_bytes.push_back(8'(len));
    end else begin
      hi  = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 2)) : 8'h00;
      len = 32'({hi, 8'($urandom_range(0, 12))});
      frame_bytes.push_back(LEN_TWO_BYTE);
      frame_bytes.push_back(hi);
      frame_bytes.push_back(8'(len));
    end
    repeat (len) frame_bytes.push_back(8'($urandom));
  endtask

  // mostly well-formed buffers, some cut short, some noise, some with a bad length byte
  task automatic build_frame(input logic [7:0] want);
    int kind;
    int cut;
    frame_bytes.delete();
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      repeat ($urandom_range(1, 4))
        push_item(($urandom_range(0, 2) == 0) ? want : 8'($urandom));
      if (kind >= 12 && frame_bytes.size() > 1) begin
        cut = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
    end else if (kind < 17) begin
      repeat ($urandom_range(1, 16)) frame_bytes.push_back(8'($urandom));
    end else begin
      if ($urandom_range(0, 1) == 0) push_item(8'($urandom));
      frame_bytes.push_back(want);
      frame_bytes.push_back(($urandom_range(0, 3) == 0) ? LEN_LONG_MARK :
                            8'($urandom_range(8'h83, 8'hFF)));
      frame_bytes.push_back(want);
      frame_bytes.push_back(8'h01);
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  // buffers at and past the length limit
  task automatic build_long_frame(input int variant, input logic [7:0] want);
    frame_bytes.delete();
    if (variant == 0) begin
      // value ends exactly on the last allowed byte
      frame_bytes.push_back(want);
      frame_bytes.push_back(LEN_TWO_BYTE);
      frame_bytes.push_back(8'h0F);
      frame_bytes.push_back(8'hFC);
      while (frame_bytes.size() < BUFFER_BYTES) frame_bytes.push_back(8'($urandom));
    end else begin
      push_item(want);
      while (frame_bytes.size() < BUFFER_BYTES + ((variant == 1) ? 1 : $urandom_range(2, 40)))
        frame_bytes.push_back(8'($urandom));
    end
  endtask

  // stimulus
  initial begin : drive_bytes
    int frames;
    int random_bytes;
    logic [7:0] want;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.data_byte  = 8'h00;
    in_chan.last_byte  = 1'b0;
    in_chan.target_tag = 8'h00;
    offer_typed        = 1'b0;
    offer_want         = '0;
    src_burst          = 1'b0;
    frames             = 0;
    random_bytes       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].tag, DIRECTED[i].typed,
                DIRECTED[i].want);

    // random buffers, with the length-limit cases spread in early
    while (random_bytes < RANDOM_BYTES) begin
      want = 8'($urandom);
      if (frames == 3 || frames == 6 || frames == 9) begin
        src_burst = 1'b1;
        build_long_frame(frames / 3 - 1, want);
      end else begin
        src_burst = ($urandom_range(0, 3) == 0);
        build_frame(want);
        random_bytes += frame_bytes.size();
      end
      send_frame(want);
      frames++;
    end
    @(negedge clk);
    in_chan.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d buffers, %0d bytes: %0d found, %0d not found, %0d over the limit",
             results_seen, bytes_sent, found_count, missing_count, too_long_count);
    $display("result side held off once for %0d cycles while bytes kept coming", HOLD_CYCLES);
    if (errors == 0) begin
      $display("[tlv_tag_finder] OK");
    end else begin
      $display("[tlv_tag_finder] ERROR");
    end
    $finish;
  end

  // result-side pacing, with one long hold-off while input keeps streaming
  initial begin : pace_results
    int run;
    int gap;
    out_chan.ready = 1'b0;
    hold_done      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= 15) begin
        hold_done = 1'b1;
        @(negedge clk);
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      @(negedge clk);
      out_chan.ready = 1'b1;
      repeat (run - 1) @(negedge clk);
      gap = idle_cycles();
      if (gap > 0) begin
        @(negedge clk);
        out_chan.ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // predict on each input transaction, check each result transaction
  always @(posedge clk) begin : track_transactions
    search_result_t predicted;
    search_result_t want;
    if (!rst_n) begin
      clear_search();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        if (predict_byte(in_chan.data_byte, in_chan.last_byte, in_chan.target_tag, predicted))
          pending_results.push_back(offer_typed ? offer_want : predicted);
      end
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with none pending, status", out_chan.search_status, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_chan.search_status !== want.search_status)
            report_mismatch("search_status", out_chan.search_status, want.search_status);
          if (out_chan.value_offset !== want.value_offset)
            report_mismatch("value_offset", out_chan.value_offset, want.value_offset);
          if (out_chan.value_length !== want.value_length)
            report_mismatch("value_length", out_chan.value_length, want.value_length);
          case (want.search_status)
            STATUS_FOUND:     found_count++;
            STATUS_NOT_FOUND: missing_count++;
            default:          too_long_count++;
          endcase
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("[tlv_tag_finder] ERROR");
      $finish;
    end
  end

endmodule

`default_nettype wire

@@ tlv_tag_finder.f @@
design/tlv_pkg.sv
design/tlv_in_if.sv
design/tlv_out_if.sv
design/tlv_tag_finder.sv
design/tlv_chk.sv
tb/tlv_tag_finder_tb.sv
